@@ src/pimrwd_pkg.sv @@
// Package for the PIM register-file write deserializer.
// Holds field widths, configuration register codes and the item structs.
// No dependencies.
package pimrwd_pkg;

    localparam int BEAT_BITS          = 16;
    localparam int ROW_WIDTH          = 14;
    localparam int IDX_W              = ROW_WIDTH - 1;
    localparam int WORD_W             = 64;
    localparam int BEATS_PER_WORD_DEF = 4;
    localparam int CFG_IDX_W          = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIM_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRF_INDEX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRF_A_INDEX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRF_B_INDEX = 2'd3;

    localparam logic [IDX_W-1:0] CRF_INDEX_RST   = 13'd0;
    localparam logic [IDX_W-1:0] GRF_A_INDEX_RST = 13'd3;
    localparam logic [IDX_W-1:0] GRF_B_INDEX_RST = 13'd4;

    typedef struct packed {
        logic             pim_enable;
        logic [IDX_W-1:0] crf_index;
        logic [IDX_W-1:0] grf_a_index;
        logic [IDX_W-1:0] grf_b_index;
    } cfg_t;

    typedef struct packed {
        logic [ROW_WIDTH-1:0] row_address;
        logic                 read_strobe;
        logic                 write_strobe;
        logic [BEAT_BITS-1:0] dq_beat;
    } in_item_t;

    typedef struct packed {
        logic              decode_enable;
        logic              file_access;
        logic [WORD_W-1:0] file_word;
    } out_item_t;

endpackage

@@ src/pimrwd_cfg_regs.sv @@
// Configuration registers of the PIM register-file write deserializer.
// Depends on pimrwd_pkg for register codes, reset values and cfg_t.
module pimrwd_cfg_regs
    import pimrwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IDX_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PIM_ENABLE:  cfg_next.pim_enable  = cfg_data[0];
                CFG_CRF_INDEX:   cfg_next.crf_index   = cfg_data;
                CFG_GRF_A_INDEX: cfg_next.grf_a_index = cfg_data;
                CFG_GRF_B_INDEX: cfg_next.grf_b_index = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pim_enable  <= 1'b0;
            cfg_reg.crf_index   <= CRF_INDEX_RST;
            cfg_reg.grf_a_index <= GRF_A_INDEX_RST;
            cfg_reg.grf_b_index <= GRF_B_INDEX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/pimrwd_in_reg.sv @@
// Input register of the PIM register-file write deserializer.
// Holds one accepted word until the gather stage takes it. Depends on pimrwd_pkg.
module pimrwd_in_reg
    import pimrwd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    input  logic     item_take,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Refill in the same cycle the held word moves on
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ src/pimrwd_gather.sv @@
// Beat gather stage and result register of the PIM register-file write deserializer.
// Keeps the CRF and GRF gather state. Depends on pimrwd_pkg.
module pimrwd_gather
    import pimrwd_pkg::*;
#(
    parameter int BEATS_PER_WORD = BEATS_PER_WORD_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      item_valid,
    output logic      item_take,
    input  in_item_t  item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int CNT_W  = $clog2(BEATS_PER_WORD);
    localparam int GBUF_W = (BEATS_PER_WORD - 1) * BEAT_BITS;
    localparam int FULL_W = BEATS_PER_WORD * BEAT_BITS;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BEATS_PER_WORD - 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [GBUF_W-1:0]    gbuf_reg;
    logic [GBUF_W-1:0]    gbuf_next;
    logic                 cpend_reg;
    logic                 cpend_next;
    logic [BEAT_BITS-1:0] cbuf_reg;
    logic [BEAT_BITS-1:0] cbuf_next;
    logic                 out_valid_reg;
    out_item_t            out_reg;
    out_item_t            out_next;

    logic                     rmsb;
    logic [IDX_W-1:0]         rlsb;
    logic                     wr_only;
    logic [FULL_W+WORD_W-1:0] full_ext;

    assign rmsb      = item.row_address[ROW_WIDTH-1];
    assign rlsb      = item.row_address[ROW_WIDTH-2:0];
    assign wr_only   = item.write_strobe && !item.read_strobe;
    assign full_ext  = {{WORD_W{1'b0}}, item.dq_beat, gbuf_reg};
    assign item_take = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        out_next   = '0;
        cnt_next   = cnt_reg;
        gbuf_next  = gbuf_reg;
        cpend_next = cpend_reg;
        cbuf_next  = cbuf_reg;
        if (cfg.pim_enable)
        begin
            if (!rmsb)
            begin
                // Normal row: decode, drop any GRF burst
                out_next.decode_enable = item.read_strobe || item.write_strobe;
                cnt_next               = '0;
            end
            else if (cnt_reg == '0 && !cpend_reg)
            begin
                if (rlsb <= cfg.grf_b_index)
                begin
                    if (rlsb == cfg.crf_index && wr_only)
                    begin
                        cpend_next = 1'b1;
                        cbuf_next  = item.dq_beat;
                    end
                    else if (rlsb < cfg.grf_a_index)
                    begin
                        out_next.file_word   = WORD_W'(item.dq_beat);
                        out_next.file_access = wr_only;
                    end
                    else if (wr_only)
                    begin
                        cnt_next                   = CNT_W'(1);
                        gbuf_next[BEAT_BITS-1:0]   = item.dq_beat;
                    end
                end
            end
            else if (cpend_reg)
            begin
                cpend_next           = 1'b0;
                out_next.file_word   = WORD_W'({item.dq_beat, cbuf_reg});
                out_next.file_access = 1'b1;
            end
            else if (cnt_reg < LAST_CNT)
            begin
                gbuf_next[cnt_reg*BEAT_BITS +: BEAT_BITS] = item.dq_beat;
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                cnt_next             = '0;
                out_next.file_word   = full_ext[WORD_W-1:0];
                out_next.file_access = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                cnt_reg   <= cnt_next;
                cpend_reg <= cpend_next;
            end
            out_valid_reg <= item_take || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            gbuf_reg <= gbuf_next;
            cbuf_reg <= cbuf_next;
            out_reg  <= out_next;
        end
    end

endmodule

@@ src/pim_register_write_deserializer.sv @@
// Top level of the PIM register-file write deserializer.
// Instantiates pimrwd_cfg_regs, pimrwd_in_reg and pimrwd_gather; uses pimrwd_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   s_*     | in        | s_tvalid/s_tready  | tdata: row_address, dq_beat; tuser: strobes
//   m_*     | out       | m_tvalid/m_tready  | tdata: file_word; tuser: decode, access
//   cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word is accepted every cycle while s_tready is high; its result reaches m_* through
// the input register, then the gather logic into the result register.
// The gather state sits next to the result register, so each beat sees the state left
// by the one before it. rst_n clears all control state and the config registers.
// A stall on m_tready holds the result and fills the input register, then s_tready drops.
module pim_register_write_deserializer
    import pimrwd_pkg::*;
#(
    parameter int BEATS_PER_WORD = BEATS_PER_WORD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [13:0] row_address, [29:14] dq_beat, rest zero
    input  logic [1:0]           s_tuser,   // [0] read_strobe, [1] write_strobe
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_W-1:0]    m_tdata,   // [63:0] file_word
    output logic [1:0]           m_tuser,   // [0] decode_enable, [1] file_access
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IDX_W-1:0]     cfg_data
);

    cfg_t      cfg;
    in_item_t  s_item;
    in_item_t  item;
    logic      item_valid;
    logic      item_take;
    out_item_t m_item;

    assign s_item.row_address  = s_tdata[ROW_WIDTH-1:0];
    assign s_item.dq_beat      = s_tdata[ROW_WIDTH+BEAT_BITS-1:ROW_WIDTH];
    assign s_item.read_strobe  = s_tuser[0];
    assign s_item.write_strobe = s_tuser[1];

    assign m_tdata    = m_item.file_word;
    assign m_tuser[0] = m_item.decode_enable;
    assign m_tuser[1] = m_item.file_access;

    pimrwd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pimrwd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    pimrwd_gather #(
        .BEATS_PER_WORD (BEATS_PER_WORD)
    ) u_gather (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (m_item)
    );

endmodule

@@ src/pimrwd_checker.sv @@
// Port-level checker for the PIM register-file write deserializer, with its bind.
// Sees only the top-level ports; depends on pimrwd_pkg.
module pimrwd_checker
    import pimrwd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [WORD_W-1:0]    m_tdata,
    input logic [1:0]           m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Decode and file access come from disjoint rows
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("decode and file access together");

    // A normal-row result carries no word
    a_dec_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("decode result with nonzero word");

    // With the output free, the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind pim_register_write_deserializer pimrwd_checker u_pimrwd_checker (.*);
